// ----- design/npc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg : shared types for the nearest point correspondence block
// Point layout, distance width, result status codes and the control word of
// the shared subtract/square/accumulate unit.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int COORD_W   = 20;            // signed Q16.4 coordinate
    localparam int DIFF_W    = COORD_W + 1;   // coordinate difference
    localparam int DIST_W    = 2 * DIFF_W;    // squared distance, sum of three squares
    localparam int THR_W     = 20;            // unsigned Q16.4 threshold
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MATCH = 2'd0,
        STATUS_DIST  = 2'd1,
        STATUS_DUP   = 2'd2
    } status_t;

    // operand select for the difference register
    typedef enum logic [1:0] {
        OPND_X   = 2'd0,
        OPND_Y   = 2'd1,
        OPND_Z   = 2'd2,
        OPND_THR = 2'd3
    } opnd_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic      load_diff;
        opnd_sel_t sel;
        logic      square;
        acc_op_t   acc;
    } su_ctrl_t;

endpackage
`default_nettype wire

// ----- design/npc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_ram : generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH  = 60,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/npc_sq_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_sq_unit : shared subtract / square / accumulate unit
// One 21x21 signed multiplier, used for every coordinate square of every
// distance and once per run for the threshold square.
// ----------------------------------------------------------------------------
module npc_sq_unit (
    input  logic                       aclk,
    input  npc_pkg::su_ctrl_t          ctrl,
    input  npc_pkg::point_t            ref_pt,
    input  npc_pkg::point_t            cur_pt,
    input  logic [npc_pkg::THR_W-1:0]  thr,
    output npc_pkg::dist_t             prod,
    output npc_pkg::dist_t             sum
);
    import npc_pkg::*;

    logic signed [DIFF_W-1:0]   opnd_a;
    logic signed [DIFF_W-1:0]   opnd_b;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIST_W-1:0]   sq;
    dist_t                      prod_reg;
    dist_t                      acc_reg;

    always_comb begin
        case (ctrl.sel)
            OPND_X: begin
                opnd_a = {ref_pt.x[COORD_W-1], ref_pt.x};
                opnd_b = {cur_pt.x[COORD_W-1], cur_pt.x};
            end
            OPND_Y: begin
                opnd_a = {ref_pt.y[COORD_W-1], ref_pt.y};
                opnd_b = {cur_pt.y[COORD_W-1], cur_pt.y};
            end
            OPND_Z: begin
                opnd_a = {ref_pt.z[COORD_W-1], ref_pt.z};
                opnd_b = {cur_pt.z[COORD_W-1], cur_pt.z};
            end
            default: begin
                opnd_a = {1'b0, thr};
                opnd_b = '0;
            end
        endcase
    end

    assign sq = diff_reg * diff_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_diff) begin
            diff_reg <= opnd_a - opnd_b;
        end
        if (ctrl.square) begin
            prod_reg <= dist_t'(sq);
        end
        case (ctrl.acc)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:  acc_reg <= acc_reg;
        endcase
    end

    assign prod = prod_reg;
    assign sum  = acc_reg + prod_reg;   // < 3 * 2^40, no carry out

endmodule
`default_nettype wire

// ----- design/npc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_ctrl : sequencer of the nearest point correspondence block
// Load counters, threshold register, match search loop, duplicate tracking
// and the result output register.
// ----------------------------------------------------------------------------
module npc_ctrl #(
    parameter int MAX_REFERENCE = 16,
    parameter int MAX_CURRENT   = 16,
    localparam int REF_IDX_W = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1,
    localparam int CUR_IDX_W = (MAX_CURRENT > 1) ? $clog2(MAX_CURRENT) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  npc_pkg::coord_t                s_coord_x,
    input  npc_pkg::coord_t                s_coord_y,
    input  npc_pkg::coord_t                s_coord_z,
    input  logic                           s_set_end,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [npc_pkg::STATUS_W-1:0]   m_status,
    output npc_pkg::coord_t                m_out_x,
    output npc_pkg::coord_t                m_out_y,
    output npc_pkg::coord_t                m_out_z,
    output logic [npc_pkg::OUT_IDX_W-1:0]  m_matched_index,
    output logic                           m_final_result,
    // threshold register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npc_pkg::THR_W-1:0]      cfg_data,
    // shared unit
    output npc_pkg::su_ctrl_t              su_ctrl,
    output logic [npc_pkg::THR_W-1:0]      thr,
    input  npc_pkg::dist_t                 prod,
    input  npc_pkg::dist_t                 sum,
    // point stores
    output logic                           ref_we,
    output logic [REF_IDX_W-1:0]           ref_waddr,
    output logic [REF_IDX_W-1:0]           ref_raddr,
    input  npc_pkg::point_t                ref_rdata,
    output logic                           cur_we,
    output logic [CUR_IDX_W-1:0]           cur_waddr,
    output logic [CUR_IDX_W-1:0]           cur_raddr,
    input  npc_pkg::point_t                cur_rdata,
    output npc_pkg::point_t                wdata
);
    import npc_pkg::*;

    localparam int REF_CNT_W = $clog2(MAX_REFERENCE + 1);
    localparam int CUR_CNT_W = $clog2(MAX_CURRENT + 1);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(160);

    // steps of one distance evaluation
    localparam logic [2:0] PH_WAIT = 3'd0;   // store read in flight
    localparam logic [2:0] PH_X    = 3'd1;
    localparam logic [2:0] PH_Y    = 3'd2;
    localparam logic [2:0] PH_Z    = 3'd3;
    localparam logic [2:0] PH_LAST = 3'd4;
    localparam logic [2:0] PH_CMP  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_THR0, S_THR1, S_THR2, S_EVAL, S_CHECK,
        S_OREAD, S_OLOAD, S_FAIL, S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [REF_CNT_W-1:0]   ref_cnt_reg, ref_cnt_next;
    logic [CUR_CNT_W-1:0]   cur_cnt_reg, cur_cnt_next;
    logic [REF_IDX_W-1:0]   ri_reg, ri_next;
    logic [CUR_IDX_W-1:0]   cj_reg, cj_next;
    logic [2:0]             phase_reg, phase_next;
    logic [MAX_CURRENT-1:0] used_reg, used_next;
    logic                   dup_reg, dup_next;
    logic [THR_W-1:0]       thr_reg, thr_next;
    logic                   m_valid_reg, m_valid_next;

    status_t                fail_status_reg, fail_status_next;
    dist_t                  thr2_reg, thr2_next;
    dist_t                  best_reg, best_next;
    logic [CUR_IDX_W-1:0]   bi_reg, bi_next;
    logic [CUR_IDX_W-1:0]   match_idx_reg [MAX_REFERENCE];
    logic [CUR_IDX_W-1:0]   match_idx_next [MAX_REFERENCE];
    status_t                m_status_reg, m_status_next;
    coord_t                 m_x_reg, m_x_next;
    coord_t                 m_y_reg, m_y_next;
    coord_t                 m_z_reg, m_z_next;
    logic [OUT_IDX_W-1:0]   m_idx_reg, m_idx_next;
    logic                   m_final_reg, m_final_next;

    logic ref_room, cur_room, ri_last, cj_last, out_free, dup_any;

    assign ref_room = ref_cnt_reg < REF_CNT_W'(MAX_REFERENCE);
    assign cur_room = cur_cnt_reg < CUR_CNT_W'(MAX_CURRENT);
    assign ri_last  = (REF_CNT_W'(ri_reg) + REF_CNT_W'(1)) == ref_cnt_reg;
    assign cj_last  = (CUR_CNT_W'(cj_reg) + CUR_CNT_W'(1)) == cur_cnt_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign dup_any  = dup_reg || used_reg[bi_reg];

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    assign wdata     = '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
    assign ref_waddr = ref_cnt_reg[REF_IDX_W-1:0];
    assign cur_waddr = cur_cnt_reg[CUR_IDX_W-1:0];
    assign ref_raddr = ri_reg;
    assign cur_raddr = (state_reg == S_OREAD || state_reg == S_OLOAD)
                       ? match_idx_reg[ri_reg] : cj_reg;

    always_comb begin
        state_next       = state_reg;
        ref_cnt_next     = ref_cnt_reg;
        cur_cnt_next     = cur_cnt_reg;
        ri_next          = ri_reg;
        cj_next          = cj_reg;
        phase_next       = phase_reg;
        used_next        = used_reg;
        dup_next         = dup_reg;
        thr_next         = thr_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        fail_status_next = fail_status_reg;
        thr2_next        = thr2_reg;
        best_next        = best_reg;
        bi_next          = bi_reg;
        match_idx_next   = match_idx_reg;
        m_status_next    = m_status_reg;
        m_x_next         = m_x_reg;
        m_y_next         = m_y_reg;
        m_z_next         = m_z_reg;
        m_idx_next       = m_idx_reg;
        m_final_next     = m_final_reg;
        su_ctrl          = '{load_diff: 1'b0, sel: OPND_X, square: 1'b0, acc: ACC_HOLD};
        ref_we           = 1'b0;
        cur_we           = 1'b0;

        if (cfg_valid) begin
            thr_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ri_next    = '0;
                    cj_next    = '0;
                    phase_next = PH_WAIT;
                    used_next  = '0;
                    dup_next   = 1'b0;
                    if (!s_mode) begin
                        if (ref_room) begin
                            ref_we       = 1'b1;
                            ref_cnt_next = ref_cnt_reg + REF_CNT_W'(1);
                        end
                    end else begin
                        if (cur_room) begin
                            cur_we       = 1'b1;
                            cur_cnt_next = cur_cnt_reg + CUR_CNT_W'(1);
                        end
                        if (s_set_end) begin
                            state_next = (ref_cnt_reg == '0) ? S_DONE : S_THR0;
                        end
                    end
                end
            end
            S_THR0: begin
                su_ctrl.load_diff = 1'b1;
                su_ctrl.sel       = OPND_THR;
                state_next        = S_THR1;
            end
            S_THR1: begin
                su_ctrl.square = 1'b1;
                state_next     = S_THR2;
            end
            S_THR2: begin
                thr2_next  = prod;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    PH_WAIT: ;
                    PH_X: begin
                        su_ctrl.load_diff = 1'b1;
                        su_ctrl.sel       = OPND_X;
                    end
                    PH_Y: begin
                        su_ctrl.load_diff = 1'b1;
                        su_ctrl.sel       = OPND_Y;
                        su_ctrl.square    = 1'b1;
                    end
                    PH_Z: begin
                        su_ctrl.load_diff = 1'b1;
                        su_ctrl.sel       = OPND_Z;
                        su_ctrl.square    = 1'b1;
                        su_ctrl.acc       = ACC_LOAD;
                    end
                    PH_LAST: begin
                        su_ctrl.square = 1'b1;
                        su_ctrl.acc    = ACC_ADD;
                    end
                    PH_CMP: begin
                        // strict less-than keeps the lowest index on a tie
                        if (cj_reg == '0 || sum < best_reg) begin
                            best_next = sum;
                            bi_next   = cj_reg;
                        end
                        phase_next = PH_WAIT;
                        if (cj_last) begin
                            state_next = S_CHECK;
                        end else begin
                            cj_next = cj_reg + CUR_IDX_W'(1);
                        end
                    end
                    default: phase_next = PH_WAIT;
                endcase
            end
            S_CHECK: begin
                match_idx_next[ri_reg] = bi_reg;
                if (best_reg > thr2_reg) begin
                    fail_status_next = STATUS_DIST;
                    state_next       = S_FAIL;
                end else begin
                    used_next[bi_reg] = 1'b1;
                    dup_next          = dup_any;
                    if (ri_last) begin
                        ri_next = '0;
                        if (dup_any) begin
                            fail_status_next = STATUS_DUP;
                            state_next       = S_FAIL;
                        end else begin
                            state_next = S_OREAD;
                        end
                    end else begin
                        ri_next    = ri_reg + REF_IDX_W'(1);
                        cj_next    = '0;
                        phase_next = PH_WAIT;
                        state_next = S_EVAL;
                    end
                end
            end
            S_OREAD: state_next = S_OLOAD;
            S_OLOAD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_MATCH;
                    m_x_next      = cur_rdata.x;
                    m_y_next      = cur_rdata.y;
                    m_z_next      = cur_rdata.z;
                    m_idx_next    = OUT_IDX_W'(match_idx_reg[ri_reg]);
                    m_final_next  = ri_last;
                    if (ri_last) begin
                        state_next = S_DONE;
                    end else begin
                        ri_next    = ri_reg + REF_IDX_W'(1);
                        state_next = S_OREAD;
                    end
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = fail_status_reg;
                    m_x_next      = '0;
                    m_y_next      = '0;
                    m_z_next      = '0;
                    m_idx_next    = '0;
                    m_final_next  = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                ref_cnt_next = '0;
                cur_cnt_next = '0;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        fail_status_reg <= fail_status_next;
        thr2_reg        <= thr2_next;
        best_reg        <= best_next;
        bi_reg          <= bi_next;
        match_idx_reg   <= match_idx_next;
        m_status_reg    <= m_status_next;
        m_x_reg         <= m_x_next;
        m_y_reg         <= m_y_next;
        m_z_reg         <= m_z_next;
        m_idx_reg       <= m_idx_next;
        m_final_reg     <= m_final_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ref_cnt_reg <= '0;
            cur_cnt_reg <= '0;
            ri_reg      <= '0;
            cj_reg      <= '0;
            phase_reg   <= PH_WAIT;
            used_reg    <= '0;
            dup_reg     <= 1'b0;
            thr_reg     <= THR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ref_cnt_reg <= ref_cnt_next;
            cur_cnt_reg <= cur_cnt_next;
            ri_reg      <= ri_next;
            cj_reg      <= cj_next;
            phase_reg   <= phase_next;
            used_reg    <= used_next;
            dup_reg     <= dup_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_out_x         = m_x_reg;
    assign m_out_y         = m_y_reg;
    assign m_out_z         = m_z_reg;
    assign m_matched_index = m_idx_reg;
    assign m_final_result  = m_final_reg;

    // result register is only ever loaded from the two emit states
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OLOAD || $past(state_reg) == S_FAIL))
        else $error("result raised outside an emit state");

    a_fail_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STATUS_MATCH) |->
            (m_final_reg && m_idx_reg == '0 && m_x_reg == '0 && m_y_reg == '0 && m_z_reg == '0))
        else $error("failure result not final or not zeroed");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ref_cnt_reg <= REF_CNT_W'(MAX_REFERENCE) && cur_cnt_reg <= CUR_CNT_W'(MAX_CURRENT))
        else $error("point count beyond store depth");

    a_run_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> (ref_cnt_reg == '0 && cur_cnt_reg == '0 && state_reg == S_IDLE))
        else $error("counts not cleared after run");

    a_cur_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EVAL |-> CUR_CNT_W'(cj_reg) < cur_cnt_reg)
        else $error("current point index beyond loaded count");

endmodule
`default_nettype wire

// ----- design/nearest_point_correspondence.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_correspondence : nearest neighbour matching of 3D point sets
// Loads a reference set and a current set, then matches every reference
// point to its nearest current point and emits the matches or one failure.
// ----------------------------------------------------------------------------
// Points arrive one per transfer on the s_ channel: s_mode 0 loads a
// reference point, s_mode 1 a current point; points beyond MAX_REFERENCE or
// MAX_CURRENT are dropped. Loading accepts one point per cycle. A current
// point with s_set_end high starts a run: every reference point in load
// order is compared against every current point by squared distance (ties
// to the lower index) and the nearest one is taken. Each distance is
// computed on the single shared 21x21 multiplier in steps (one store read,
// three squares, accumulate, compare); s_ready stays low for the whole
// run. If a best distance exceeds distance_threshold (compared as squares)
// a single status 1 result is sent; if two references picked the same
// current point a single status 2 result is sent; otherwise one status 0
// result per reference point follows in reference order, the last with
// m_final_result set. Both point sets are emptied at the end of a run. A
// run with no reference points sends nothing. The threshold (reset 160,
// i.e. 10.0 pixels) is written through the cfg_ channel, which is always
// ready; write it only while idle.
// ----------------------------------------------------------------------------
module nearest_point_correspondence #(
    parameter int MAX_REFERENCE = 16,
    parameter int MAX_CURRENT   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // point input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  npc_pkg::coord_t                s_coord_x,
    input  npc_pkg::coord_t                s_coord_y,
    input  npc_pkg::coord_t                s_coord_z,
    input  logic                           s_set_end,
    // match results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [npc_pkg::STATUS_W-1:0]   m_status,
    output npc_pkg::coord_t                m_out_x,
    output npc_pkg::coord_t                m_out_y,
    output npc_pkg::coord_t                m_out_z,
    output logic [npc_pkg::OUT_IDX_W-1:0]  m_matched_index,
    output logic                           m_final_result,
    // distance_threshold write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npc_pkg::THR_W-1:0]      cfg_data
);
    import npc_pkg::*;

    localparam int REF_IDX_W = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
    localparam int CUR_IDX_W = (MAX_CURRENT > 1) ? $clog2(MAX_CURRENT) : 1;

    su_ctrl_t              su_ctrl;
    logic [THR_W-1:0]      thr;
    dist_t                 prod;
    dist_t                 sum;

    logic                  ref_we;
    logic [REF_IDX_W-1:0]  ref_waddr;
    logic [REF_IDX_W-1:0]  ref_raddr;
    point_t                ref_rdata;
    logic                  cur_we;
    logic [CUR_IDX_W-1:0]  cur_waddr;
    logic [CUR_IDX_W-1:0]  cur_raddr;
    point_t                cur_rdata;
    point_t                wdata;

    // sequencer: load counts, search loop, duplicate check, result register
    npc_ctrl #(
        .MAX_REFERENCE (MAX_REFERENCE),
        .MAX_CURRENT   (MAX_CURRENT)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .s_set_end       (s_set_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_matched_index (m_matched_index),
        .m_final_result  (m_final_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .su_ctrl         (su_ctrl),
        .thr             (thr),
        .prod            (prod),
        .sum             (sum),
        .ref_we          (ref_we),
        .ref_waddr       (ref_waddr),
        .ref_raddr       (ref_raddr),
        .ref_rdata       (ref_rdata),
        .cur_we          (cur_we),
        .cur_waddr       (cur_waddr),
        .cur_raddr       (cur_raddr),
        .cur_rdata       (cur_rdata),
        .wdata           (wdata)
    );

    // reference point store
    npc_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_REFERENCE)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    // current point store; also read back for the matched coordinates
    npc_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_CURRENT)
    ) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    // the one multiplier: coordinate differences squared and summed
    npc_sq_unit u_sq_unit (
        .aclk   (aclk),
        .ctrl   (su_ctrl),
        .ref_pt (ref_rdata),
        .cur_pt (cur_rdata),
        .thr    (thr),
        .prod   (prod),
        .sum    (sum)
    );

endmodule
`default_nettype wire
